>>> rtl/cms_pkg.sv
// Shared types and constants for the convex minorant slope block.
package cms_pkg;

    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 40;
    localparam int SLOPE_W  = 48;
    localparam int FIT_W    = 17;
    localparam int IDX_W    = 6;
    localparam int NUM_W    = SUM_W + 1 + 16;
    localparam int DEN_W    = WEIGHT_W + 1;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(65536);

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_RD_B,
        OP_RD_A,
        OP_DIV_START,
        OP_WR_SLOPE,
        OP_RD_PREV,
        OP_FILL,
        OP_RD_OUT,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IDX_W-1:0] addr;
        logic             origin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic prev_gt;
    } t_stat;

endpackage

>>> rtl/cms_div.sv
// Sequential signed divider, one quotient bit per cycle, with saturation.
module cms_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [cms_pkg::NUM_W-1:0]   i_num,
    input  logic signed [cms_pkg::DEN_W-1:0]   i_den,
    output logic                               o_done,
    output logic signed [cms_pkg::SLOPE_W-1:0] o_quot
);
    import cms_pkg::*;

    localparam int MAG_W = NUM_W;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]  r_rem_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_neg;
    logic              r_done;
    logic signed [SLOPE_W-1:0] r_quot;

    logic [DEN_W:0]    n_trial;
    logic [DEN_W:0]    n_shift;
    logic [MAG_W:0]    n_sq;
    logic signed [MAG_W+1:0] n_sres;

    // shift one bit of the dividend into the partial remainder
    always_comb begin
        n_shift = {r_rem, r_rem_q[MAG_W-1]};
        n_trial = n_shift - {1'b0, r_den};
        n_sq    = {1'b0, r_rem_q[MAG_W-2:0], ~n_trial[DEN_W]};
        n_sres  = r_neg ? -$signed({2'b00, n_sq[MAG_W-1:0]})
                        : $signed({2'b00, n_sq[MAG_W-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(MAG_W);
                r_neg   <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
                r_rem_q <= i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
                r_den   <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
                r_rem   <= '0;
            end else if (r_busy) begin
                r_rem   <= n_trial[DEN_W] ? n_shift[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_rem_q <= n_sq[MAG_W-1:0];
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    // saturate to the slope range
                    if (n_sres > $signed({{(MAG_W+2-SLOPE_W){1'b0}}, SLOPE_MAX}))
                        r_quot <= SLOPE_MAX;
                    else if (n_sres < $signed({{(MAG_W+2-SLOPE_W){1'b1}}, SLOPE_MIN}))
                        r_quot <= SLOPE_MIN;
                    else
                        r_quot <= n_sres[SLOPE_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/cms_dp.sv
// Datapath: point and slope memories, difference unit, divider, clip.
module cms_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cms_pkg::t_cmd                   i_cmd,
    input  logic [cms_pkg::WEIGHT_W-1:0]    i_cum_weight,
    input  logic signed [cms_pkg::SUM_W-1:0] i_cum_sum,
    output cms_pkg::t_stat                  o_stat,
    output logic [cms_pkg::FIT_W-1:0]       o_fitted_value
);
    import cms_pkg::*;

    localparam int DEPTH = MAX_POINTS;

    logic [WEIGHT_W-1:0]        r_wmem [DEPTH];
    logic signed [SUM_W-1:0]    r_smem [DEPTH];
    logic signed [SLOPE_W-1:0]  r_slmem [DEPTH];

    logic [WEIGHT_W-1:0]        r_wb, r_wa, r_wrd;
    logic signed [SUM_W-1:0]    r_sb, r_sa, r_srd;
    logic signed [SLOPE_W-1:0]  r_cur, r_slrd;
    logic                       r_spec;
    logic signed [SLOPE_W-1:0]  r_spec_val;
    logic                       r_done;

    logic signed [NUM_W-1:0]    n_num;
    logic signed [DEN_W-1:0]    n_den;
    logic                       w_div_done;
    logic signed [SLOPE_W-1:0]  w_quot;
    logic [IDX_W-1:0]           w_addr;

    assign w_addr = i_cmd.addr;

    // difference of the two selected points
    always_comb begin
        n_den = $signed({1'b0, r_wb}) - $signed({1'b0, r_wa});
        n_num = $signed({(SUM_W+1)'(r_sb) - (SUM_W+1)'(r_sa), 16'h0000});
    end

    cms_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.op == OP_DIV_START && n_den != '0),
        .i_num  (n_num),
        .i_den  (n_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // memory ports, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_STORE) begin
            r_wmem[w_addr] <= i_cum_weight;
            r_smem[w_addr] <= i_cum_sum;
        end
        r_wrd <= r_wmem[w_addr];
        r_srd <= r_smem[w_addr];
        if (i_cmd.op == OP_WR_SLOPE || i_cmd.op == OP_FILL)
            r_slmem[w_addr] <= r_cur;
        r_slrd <= r_slmem[w_addr];
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (i_cmd.op)
                OP_DIV_START: begin
                    r_spec     <= (n_den == '0);
                    r_spec_val <= (n_num > 0) ? SLOPE_ONE : '0;
                    if (n_den == '0)
                        r_done <= 1'b1;
                end
                default: ;
            endcase
            if (r_done && r_spec)
                r_cur <= r_spec_val;
            else if (w_div_done)
                r_cur <= w_quot;
        end
    end

    // latch the addressed point from the registered read data in the cycle after the read is issued
    logic r_ld_b, r_ld_a, r_orig_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_b <= 1'b0;
            r_ld_a <= 1'b0;
        end else begin
            r_ld_b   <= i_cmd.op == OP_RD_B;
            r_ld_a   <= i_cmd.op == OP_RD_A;
            r_orig_a <= i_cmd.origin;
            if (r_ld_b) begin
                r_wb <= r_wrd;
                r_sb <= r_srd;
            end
            if (r_ld_a) begin
                r_wa <= r_orig_a ? '0 : r_wrd;
                r_sa <= r_orig_a ? '0 : r_srd;
            end
        end
    end

    assign o_stat.div_done = (r_done && r_spec) || w_div_done;
    assign o_stat.prev_gt  = r_slrd > r_cur;

    // clip the stored slope to [0, 1]
    always_comb begin
        if (r_slrd <= 0)
            o_fitted_value = '0;
        else if (r_slrd >= SLOPE_ONE)
            o_fitted_value = FIT_W'(65536);
        else
            o_fitted_value = r_slrd[FIT_W-1:0];
    end
endmodule

>>> rtl/cms_ctrl.sv
// Controller: load, pooling sequencer and output drain.
module cms_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_last_point,
    input  cms_pkg::t_stat                i_stat,
    output cms_pkg::t_cmd                 o_cmd,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cms_pkg::IDX_W-1:0]     o_point_index,
    output logic                          o_last_result
);
    import cms_pkg::*;

    localparam int CW = IDX_W + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_RDB, S_RDA, S_WAITRD, S_DIV, S_DIVW, S_WRS,
        S_RDP, S_CMP, S_FILL, S_NEXT, S_ORD, S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_i, r_j, r_m;
    logic            r_valid;
    logic [IDX_W-1:0] r_oidx;
    logic            r_olast;

    logic            w_acc;
    logic            w_oacc;
    assign w_acc  = (r_state == S_LOAD) && i_valid;
    assign w_oacc = r_valid && !i_stall;

    // command decode
    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.addr   = r_i[IDX_W-1:0];
        o_cmd.origin = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_cmd.addr = r_cnt[IDX_W-1:0];
                if (w_acc && r_cnt < CW'(MAX_POINTS))
                    o_cmd.op = OP_STORE;
            end
            S_RDB: o_cmd.op = OP_RD_B;
            S_RDA: begin
                o_cmd.op     = OP_RD_A;
                o_cmd.addr   = IDX_W'(r_j - 1'b1);
                o_cmd.origin = (r_j == '0);
            end
            S_DIV: o_cmd.op = OP_DIV_START;
            S_WRS: o_cmd.op = OP_WR_SLOPE;
            S_RDP: o_cmd.addr = IDX_W'(r_j - 1'b1);
            S_FILL: begin
                o_cmd.op   = OP_FILL;
                o_cmd.addr = r_m[IDX_W-1:0];
            end
            S_ORD: o_cmd.addr = r_i[IDX_W-1:0];
            S_OUT: o_cmd.addr = IDX_W'(r_i + (w_oacc ? 1'b1 : 1'b0));
            default: ;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: if (i_valid) begin
                    if (r_cnt < CW'(MAX_POINTS))
                        r_cnt <= r_cnt + 1'b1;
                    if (i_last_point) begin
                        r_i <= '0;
                        if (r_cnt == '0 && MAX_POINTS > 0) begin
                            r_cnt   <= CW'(1);
                            r_state <= S_RDB;
                        end else
                            r_state <= S_RDB;
                        r_j <= '0;
                    end
                end
                S_RDB: r_state <= S_RDA;
                S_RDA: r_state <= S_WAITRD;
                S_WAITRD: r_state <= S_DIV;
                S_DIV: r_state <= S_DIVW;
                S_DIVW: if (i_stat.div_done) r_state <= S_WRS;
                S_WRS: begin
                    r_m <= r_j;
                    if (r_j != r_i) r_state <= S_FILL;
                    else r_state <= S_RDP;
                end
                S_FILL: begin
                    r_m <= r_m + 1'b1;
                    if (r_m + 1'b1 >= r_i) r_state <= S_RDP;
                end
                S_RDP: begin
                    if (r_j == '0) r_state <= S_NEXT;
                    else r_state <= S_CMP;
                end
                S_CMP: begin
                    if (i_stat.prev_gt) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_RDB;
                    end else
                        r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_i     <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= r_i + 1'b1;
                        r_state <= S_RDB;
                    end
                end
                S_ORD: begin
                    r_valid <= 1'b1;
                    r_oidx  <= r_i[IDX_W-1:0];
                    r_olast <= (r_i + 1'b1 == r_cnt);
                    r_state <= S_OUT;
                end
                S_OUT: if (w_oacc) begin
                    if (r_olast) begin
                        r_valid <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_oidx  <= IDX_W'(r_i + 1'b1);
                        r_olast <= (r_i + 2'd2 == r_cnt);
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_stall       = (r_state != S_LOAD);
    assign o_valid       = r_valid;
    assign o_point_index = r_oidx;
    assign o_last_result = r_olast;
endmodule

>>> rtl/convex_minorant_slopes.sv
// Top level of the convex minorant slope block.
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_cum_weight, i_cum_sum, i_last_point
//  out     | o_valid | i_stall | o_fitted_value, o_point_index, o_last_result
// After the last point each pooling step fetches two points, divides in the
// 57-bit shift-subtract divider, writes and compares, and rewrites each slope pooled.
// A run of n points takes up to n * (n + 1) / 2 steps, then one cycle per slope out
// while the receiver does not stall.
// Reset clears the point count and controller; memories need no clearing.
// The input stalls from the last point until the final slope is transferred.
module convex_minorant_slopes #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [cms_pkg::WEIGHT_W-1:0]        i_cum_weight,
    input  logic signed [cms_pkg::SUM_W-1:0]    i_cum_sum,
    input  logic                                i_last_point,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cms_pkg::FIT_W-1:0]           o_fitted_value,
    output logic [cms_pkg::IDX_W-1:0]           o_point_index,
    output logic                                o_last_result
);
    import cms_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cms_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_last_point,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_valid, .i_stall,
        .o_point_index, .o_last_result
    );

    cms_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cum_weight, .i_cum_sum,
        .o_stat(w_stat), .o_fitted_value
    );
endmodule

>>> rtl/cms_chk.sv
// Port checker for the convex minorant slope block, bound to the top level.
module cms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [16:0] o_fitted_value,
    input logic [5:0]  o_point_index,
    input logic        o_last_result
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_index))
        else $error("stalled result changed");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fitted_value <= 17'd65536)
        else $error("slope beyond one");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while results pending");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_result |=> o_valid &&
        o_point_index == $past(o_point_index) + 6'd1)
        else $error("result index skipped");
endmodule

bind convex_minorant_slopes cms_chk u_chk (.*);

>>> verif/tb_convex_minorant_slopes.sv
// Self-checking testbench for the convex minorant slope block.
module tb_convex_minorant_slopes;
    import cms_pkg::*;

    localparam int  NPTS       = 64;
    localparam int  IDLE_LIMIT = 1000000;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    typedef struct {
        logic [WEIGHT_W-1:0]     weight;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
        bit                      drain;
    } t_point;

    typedef struct {
        logic [FIT_W-1:0] fit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_slope;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [WEIGHT_W-1:0]     i_cum_weight = '0;
    logic signed [SUM_W-1:0] i_cum_sum = '0;
    logic                    i_last_point = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [FIT_W-1:0]        o_fitted_value;
    logic [IDX_W-1:0]        o_point_index;
    logic                    o_last_result;

    convex_minorant_slopes dut (.*);

    always #5 i_clk = ~i_clk;

    t_point pending_points[$];
    t_slope expected_slopes[$];

    // predictor state
    logic [WEIGHT_W-1:0]     pred_weight[NPTS];
    logic signed [SUM_W-1:0] pred_sum[NPTS];
    logic signed [63:0]      pred_slope[NPTS];
    int                      pred_count = 0;

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  in_acc = 1'b0;

    // slope from point a (origin when a < 0) to point b, saturated to 48 bits
    function automatic logic signed [63:0] chord_slope(int a, int b);
        logic signed [63:0]  w0, s0, den, num, q;
        w0 = 0;
        s0 = 0;
        if (a >= 0) begin
            w0 = {32'd0, pred_weight[a]};
            s0 = pred_sum[a];
        end
        den = $signed({32'd0, pred_weight[b]}) - w0;
        num = (64'(pred_sum[b]) - s0) * 64'sd65536;
        if (den == 0) return (num > 0) ? ONE_Q16 : 64'sd0;
        q = num / den;
        if (q > 64'(SLOPE_MAX)) q = 64'(SLOPE_MAX);
        if (q < 64'(SLOPE_MIN)) q = 64'(SLOPE_MIN);
        return q;
    endfunction

    // load a point; on the last one pool violators and queue clipped slopes
    task automatic predict_point(t_point p);
        int j;
        t_slope s;
        logic signed [63:0] v;
        if (pred_count < NPTS) begin
            pred_weight[pred_count] = p.weight;
            pred_sum[pred_count] = p.sum;
            pred_count++;
        end
        if (!p.last) return;
        for (int i = 0; i < pred_count; i++) begin
            pred_slope[i] = chord_slope(i - 1, i);
            j = i;
            while (j > 0 && pred_slope[j-1] > pred_slope[i]) begin
                j--;
                pred_slope[i] = chord_slope(j - 1, i);
                for (int m = j; m < i; m++) pred_slope[m] = pred_slope[i];
            end
        end
        for (int i = 0; i < pred_count; i++) begin
            v = pred_slope[i];
            if (v <= 0) v = 0;
            if (v >= ONE_Q16) v = ONE_Q16;
            s.fit = v[FIT_W-1:0];
            s.idx = IDX_W'(i);
            s.last = (i == pred_count - 1);
            expected_slopes.push_back(s);
        end
        pred_count = 0;
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        return $urandom;
    endfunction

    task automatic add_point(logic [WEIGHT_W-1:0] w, logic signed [SUM_W-1:0] s,
                             logic l);
        t_point p;
        p.weight = w;
        p.sum = s;
        p.last = l;
        p.drain = 1'b0;
        pending_points.push_back(p);
    endtask

    // point set: nondecreasing weights with slopes around [0,1] (mode 0) or wide sums (mode 1), else random fields
    task automatic add_set(int n, int mode);
        logic [WEIGHT_W-1:0]     w;
        logic signed [SUM_W-1:0] s;
        logic [31:0]             dw;
        w = '0;
        s = '0;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: begin
                    dw = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 1 << 20);
                    w = w + dw;
                    s = s + SUM_W'($signed(64'(dw) * $urandom_range(0, 80000) / 65536))
                          - SUM_W'($urandom_range(0, 3000));
                end
                1: begin
                    w = w + $urandom_range(0, 1 << 24);
                    s = s + SUM_W'($signed({$urandom_range(0, 255), $urandom}))
                          - SUM_W'(64'h80_0000_0000 >> 1);
                end
                default: begin
                    w = rand_weight();
                    s = SUM_W'({$urandom, $urandom});
                end
            endcase
            add_point(w, s, k == n - 1);
        end
    endtask

    task automatic add_drain();
        t_point p;
        p.weight = '0;
        p.sum = '0;
        p.last = 1'b0;
        p.drain = 1'b1;
        pending_points.push_back(p);
    endtask

    // fill the stimulus queue
    initial begin
        // extremes of the fields, zero weight step of both signs
        add_point('0, '0, 1'b1);
        add_point(32'hFFFF_FFFF, 40'sh7F_FFFF_FFFF, 1'b0);
        add_point(32'hFFFF_FFFF, 40'sh80_0000_0000, 1'b1);
        add_point(32'h0001_0000, -40'sd65536, 1'b0);
        add_point(32'h0001_0000, 40'sd5, 1'b1);
        // decreasing weights and a pooled violator
        add_point(32'h0004_0000, 40'sh3_0000, 1'b0);
        add_point(32'h0002_0000, 40'sh1_0000, 1'b0);
        add_point(32'h0006_0000, 40'sh3_8000, 1'b1);
        add_point(32'h0000_0001, 40'sh7F_FFFF_FFFF, 1'b0);
        add_point(32'h0000_0002, 40'sh80_0000_0000, 1'b1);
        add_drain();
        // overflow: more than 64 points, last one dropped but starts the run
        add_set(NPTS + 3, 0);
        add_drain();
        for (int r = 0; r < 20; r++) begin
            case ($urandom_range(0, 9))
                0, 1:    add_set($urandom_range(1, 3), 2);
                2, 3:    add_set($urandom_range(1, 6), 1);
                default: add_set($urandom_range(1, 6), 0);
            endcase
            if (r % 10 == 9) add_drain();
        end
        for (int r = 0; r < 8; r++) add_set($urandom_range(2, 5), $urandom_range(0, 2));
        stim_done = 1'b1;
    end

    // reset sequence
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // record an input transfer at the rising edge
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_valid && !o_stall;
    end

    // driver: bursts with random gaps; a drain item waits for all slopes out
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) begin
                predict_point(pending_points.pop_front());
            end
            if (!i_valid || in_acc) begin
                while (pending_points.size() > 0 && pending_points[0].drain &&
                       expected_slopes.size() == 0)
                    void'(pending_points.pop_front());
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_points.size() > 0 && !pending_points[0].drain) begin
                    i_valid <= 1'b1;
                    i_cum_weight <= pending_points[0].weight;
                    i_cum_sum <= pending_points[0].sum;
                    i_last_point <= pending_points[0].last;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: phases of none, light and heavy stalling
    int stall_phase = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_phase = $urandom_range(0, 2);
        case (stall_phase)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // monitor: compare each slope transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_slope e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_slopes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected slope idx=%0d fit=%0d last=%0b",
                                 o_point_index, o_fitted_value, o_last_result);
                end else begin
                    e = expected_slopes.pop_front();
                    if (o_fitted_value !== e.fit || o_point_index !== e.idx ||
                        o_last_result !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"slope mismatch: exp fit=%0d idx=%0d last=%0b, ",
                                      "got fit=%0d idx=%0d last=%0b"},
                                     e.fit, e.idx, e.last,
                                     o_fitted_value, o_point_index, o_last_result);
                    end
                end
            end
            // watchdog on cycles with no transfer
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // end of run
    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (stim_done && pending_points.size() == 0 && !i_valid &&
                      expected_slopes.size() == 0);
                repeat (200) @(posedge i_clk);
                if (mismatches == 0 && expected_slopes.size() == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                $display("Verification failed");
            end
        join_any
        $finish;
    end

endmodule
